@@ rtl/kflp_pkg.sv @@
// kflp_pkg: shared types, codes and constants of the keyframe linear player
// depends on nothing; used by the ram, the divider, the top level and the checker
`default_nettype none

package kflp_pkg;

   // sizes
   localparam int unsigned MAX_KEYFRAMES_DEF = 8;
   localparam int unsigned CHANNELS          = 5;
   localparam int unsigned WORD_W            = 32;
   localparam int unsigned FRAME_W           = CHANNELS * WORD_W;
   localparam int unsigned STEPS_W           = 8;
   localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd60;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   // item kinds
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_SAVE = 2'd1;
   localparam logic [1:0] KIND_PLAY = 2'd2;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_NONE    = 3'd0,
      STATUS_STARTED = 3'd1,
      STATUS_STOPPED = 3'd2,
      STATUS_ENDED   = 3'd3,
      STATUS_SAVED   = 3'd4,
      STATUS_FULL    = 3'd5
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_A,
      ST_READ_B,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [1:0] kind;
      word_type   new_x;
      word_type   new_y;
      word_type   new_z;
      word_type   new_joint_angle;
      word_type   new_turn_angle;
   } req_payload_type;

   typedef struct packed {
      word_type   pose_x;
      word_type   pose_y;
      word_type   pose_z;
      word_type   joint_angle;
      word_type   turn_angle;
      logic       playing;
      logic [3:0] frames_stored;
      logic [2:0] segment;
      status_type status;
   } rsp_payload_type;

   typedef struct packed {
      logic [STEPS_W-1:0] steps_per_segment;
   } csr_payload_type;

endpackage

`default_nettype wire

@@ rtl/kflp_chan_if.sv @@
// kflp_chan_if: valid/ready channel carrying one payload per transaction
// the payload type is handed in by the instantiating level (types from kflp_pkg)
`default_nettype none

interface kflp_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/kflp_ram.sv @@
// kflp_ram: generic single write port, single read port ram with registered read
// depends on kflp_pkg for default sizes
`default_nettype none

module kflp_ram #(
   parameter int unsigned WIDTH = kflp_pkg::FRAME_W,
   parameter int unsigned DEPTH = kflp_pkg::MAX_KEYFRAMES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/kflp_div.sv @@
// kflp_div: serial radix-2 divider, signed 33-bit difference by unsigned 8-bit divisor
// truncates toward zero and saturates to 32 bits; depends on kflp_pkg
`default_nettype none

module kflp_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [kflp_pkg::WORD_W:0] dividend,
   input  wire logic [kflp_pkg::STEPS_W-1:0]     divisor,
   output logic                             done,
   output kflp_pkg::word_type               quotient
);
   import kflp_pkg::*;

   localparam int unsigned CNT_W = $clog2(WORD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [STEPS_W-1:0] dvs_ff, dvs_in;
   logic [STEPS_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0]  quo_ff, quo_in;

   logic signed [WORD_W:0] neg_dividend;
   logic [WORD_W-1:0]      mag;
   logic [STEPS_W:0]       rem_shift;
   logic [STEPS_W:0]       rem_diff;
   logic                   take;
   logic signed [WORD_W:0] q_ext;

   // magnitude of the dividend; a difference of two words fits 32 bits unsigned
   assign neg_dividend = -dividend;
   assign mag = dividend[WORD_W] ? neg_dividend[WORD_W-1:0] : dividend[WORD_W-1:0];

   // one restoring step per cycle
   assign rem_shift = {rem_ff, quo_ff[WORD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign take      = (rem_shift >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WORD_W - 1);
         neg_in  = dividend[WORD_W];
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = mag;
      end else if (busy_ff) begin
         rem_in = take ? rem_diff[STEPS_W-1:0] : rem_shift[STEPS_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], take};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // sign restore and saturation
   assign q_ext = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   always_comb begin
      if (q_ext[WORD_W] != q_ext[WORD_W-1]) begin
         quotient = q_ext[WORD_W] ? WORD_MIN : WORD_MAX;
      end else begin
         quotient = q_ext[WORD_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

@@ rtl/keyframe_linear_player.sv @@
// keyframe_linear_player: top level, keyframe ram, playback sequencer and pose registers
// depends on kflp_pkg, kflp_chan_if, kflp_ram and kflp_div
`default_nettype none

// Stores up to MAX_KEYFRAMES poses of five signed Q16.16 channels, one keyframe per row of a
// single ram with one write and one registered read port, and plays them back by linear
// interpolation. Every request transaction returns exactly one response transaction with the
// pose and status after it. Save, stop, plain tick and idle items go straight to the done
// state, which loads the response register. A play start or a tick that moves to a new
// segment reads the two keyframes and then computes the five increments, one channel after
// another, on one shared radix-2 divider. The block takes the next request while the response
// register still waits on the sink. No clearing pass is needed after reset: only rows below
// the stored frame count are ever read.
module keyframe_linear_player #(
   parameter int unsigned MAX_KEYFRAMES = kflp_pkg::MAX_KEYFRAMES_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   kflp_chan_if.sink   req_chan,
   kflp_chan_if.source rsp_chan,
   kflp_chan_if.sink   csr_chan
);
   import kflp_pkg::*;

   localparam int unsigned SEG_W  = $clog2(MAX_KEYFRAMES);
   localparam int unsigned CNT_W  = $clog2(MAX_KEYFRAMES + 1);
   localparam int unsigned CHAN_W = $clog2(CHANNELS);

   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   frame_count_ff, frame_count_in;
   logic               playing_ff, playing_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [STEPS_W-1:0] step_ff, step_in;
   logic [STEPS_W-1:0] steps_ff, steps_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic               start_ff, start_in;
   word_type           pose_ff [CHANNELS];
   word_type           pose_in [CHANNELS];
   word_type           inc_ff [CHANNELS];
   word_type           inc_in [CHANNELS];
   word_type           frame_a_ff [CHANNELS];
   word_type           frame_a_in [CHANNELS];
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic               wr_en;
   logic [SEG_W-1:0]   wr_addr;
   logic [FRAME_W-1:0] wr_data;
   logic               rd_en;
   logic [SEG_W-1:0]   rd_addr;
   logic [FRAME_W-1:0] rd_data;
   word_type           rd_word [CHANNELS];

   logic                   div_start;
   logic signed [WORD_W:0] div_dividend;
   logic [STEPS_W-1:0]     steps_eff;
   logic                   div_done;
   word_type               div_quot;

   logic                   req_fire;
   logic [CNT_W:0]         seg_plus3;

   function automatic word_type sat_add(word_type a, word_type b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         sat_add = s[WORD_W] ? WORD_MIN : WORD_MAX;
      end else begin
         sat_add = s[WORD_W-1:0];
      end
   endfunction

   // keyframe store, one frame per row
   kflp_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (MAX_KEYFRAMES)
   ) u_kflp_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared increment divider
   kflp_div u_kflp_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (steps_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // split the read row into channel words
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         rd_word[c] = rd_data[c*WORD_W +: WORD_W];
      end
   end

   assign wr_addr = frame_count_ff[SEG_W-1:0];
   assign wr_data = {req_chan.payload.new_turn_angle, req_chan.payload.new_joint_angle,
                     req_chan.payload.new_z, req_chan.payload.new_y, req_chan.payload.new_x};

   // next frame word minus current frame word of the channel in work
   assign div_dividend = {rd_word[chan_ff][WORD_W-1], rd_word[chan_ff]}
                       - {frame_a_ff[chan_ff][WORD_W-1], frame_a_ff[chan_ff]};
   assign steps_eff    = (steps_ff == '0) ? STEPS_W'(1) : steps_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // advanced segment plus two, checked against the frame count
   assign seg_plus3 = (CNT_W+1)'(seg_ff) + (CNT_W+1)'(3);

   // sequencer next state and datapath
   always_comb begin
      state_in       = state_ff;
      frame_count_in = frame_count_ff;
      playing_in     = playing_ff;
      seg_in         = seg_ff;
      step_in        = step_ff;
      chan_in        = chan_ff;
      start_in       = start_ff;
      status_in      = status_ff;
      pose_in        = pose_ff;
      inc_in         = inc_ff;
      frame_a_in     = frame_a_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_payload_in = rsp_payload_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = seg_ff;
      div_start      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in  = ST_DONE;
               status_in = STATUS_NONE;
               unique case (req_chan.payload.kind)
                  KIND_SAVE: begin
                     if (frame_count_ff < CNT_W'(MAX_KEYFRAMES)) begin
                        wr_en          = 1'b1;
                        frame_count_in = frame_count_ff + 1'b1;
                        status_in      = STATUS_SAVED;
                     end else begin
                        status_in = STATUS_FULL;
                     end
                  end
                  KIND_PLAY: begin
                     if (!playing_ff && frame_count_ff >= CNT_W'(2)) begin
                        playing_in = 1'b1;
                        seg_in     = '0;
                        step_in    = '0;
                        start_in   = 1'b1;
                        status_in  = STATUS_STARTED;
                        state_in   = ST_READ_A;
                     end else begin
                        playing_in = 1'b0;
                        status_in  = STATUS_STOPPED;
                     end
                  end
                  KIND_TICK: begin
                     if (playing_ff) begin
                        if (step_ff >= steps_eff) begin
                           // end of segment: move on or finish
                           if (seg_plus3 > (CNT_W+1)'(frame_count_ff)) begin
                              seg_in     = '0;
                              playing_in = 1'b0;
                              status_in  = STATUS_ENDED;
                           end else begin
                              seg_in   = seg_ff + 1'b1;
                              step_in  = '0;
                              start_in = 1'b0;
                              state_in = ST_READ_A;
                           end
                        end else begin
                           for (int c = 0; c < CHANNELS; c++) begin
                              pose_in[c] = sat_add(pose_ff[c], inc_ff[c]);
                           end
                           step_in = step_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                     status_in = STATUS_NONE;
                  end
               endcase
            end
         end
         ST_READ_A: begin
            rd_en    = 1'b1;
            rd_addr  = seg_ff;
            state_in = ST_READ_B;
         end
         ST_READ_B: begin
            // current frame arrives; fetch the next one
            for (int c = 0; c < CHANNELS; c++) begin
               frame_a_in[c] = rd_word[c];
               if (start_ff) begin
                  pose_in[c] = rd_word[c];
               end
            end
            rd_en    = 1'b1;
            rd_addr  = seg_ff + 1'b1;
            chan_in  = '0;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               inc_in[chan_ff] = div_quot;
               if (chan_ff == CHAN_W'(CHANNELS - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_DONE: begin
            // load the response register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.pose_x        = pose_ff[0];
               rsp_payload_in.pose_y        = pose_ff[1];
               rsp_payload_in.pose_z        = pose_ff[2];
               rsp_payload_in.joint_angle   = pose_ff[3];
               rsp_payload_in.turn_angle    = pose_ff[4];
               rsp_payload_in.playing       = playing_ff;
               rsp_payload_in.frames_stored = 4'(frame_count_ff);
               rsp_payload_in.segment       = 3'(seg_ff);
               rsp_payload_in.status        = status_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration register
   always_comb begin
      steps_in = steps_ff;
      if (csr_chan.valid) begin
         steps_in = csr_chan.payload.steps_per_segment;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and playback state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         playing_ff     <= 1'b0;
         seg_ff         <= '0;
         step_ff        <= '0;
         steps_ff       <= STEPS_RESET;
         chan_ff        <= '0;
         start_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            pose_ff[c] <= '0;
            inc_ff[c]  <= '0;
         end
      end else begin
         frame_count_ff <= frame_count_in;
         playing_ff     <= playing_in;
         seg_ff         <= seg_in;
         step_ff        <= step_in;
         steps_ff       <= steps_in;
         chan_ff        <= chan_in;
         start_ff       <= start_in;
         rsp_valid_ff   <= rsp_valid_in;
         pose_ff        <= pose_in;
         inc_ff         <= inc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      frame_a_ff     <= frame_a_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

`default_nettype wire

@@ rtl/kflp_checker.sv @@
// kflp_checker: port-level assertions on the keyframe linear player responses
// depends on kflp_pkg; bound to keyframe_linear_player at the end of this file
`default_nettype none

module kflp_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire kflp_pkg::rsp_payload_type rsp_payload
);
   import kflp_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // a start always reports playback from the first segment
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_STARTED
      |-> rsp_payload.playing && rsp_payload.segment == '0)
      else $error("start response without playback at segment zero");

   // an end of playback rewinds the segment
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_ENDED
      |-> !rsp_payload.playing && rsp_payload.segment == '0)
      else $error("end response still playing or not rewound");

   // stop or refuse leaves playback off
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_STOPPED |-> !rsp_payload.playing)
      else $error("stop response while playing");

endmodule

bind keyframe_linear_player kflp_checker u_kflp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire
